// File: rtl/core/gedd_pkg.sv
`timescale 1ns / 1ps

package gedd_pkg;

    // Widths fixed by the pixel format and the register map.
    localparam int PIX_W        = 8;
    localparam int ERR_W        = 8;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam int DEF_MAX_WIDTH = 1024;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // Luma weights, scaled by 256.
    localparam logic [7:0] COEF_R = 8'd77;
    localparam logic [7:0] COEF_G = 8'd150;
    localparam logic [7:0] COEF_B = 8'd29;

    // Floyd-Steinberg weights, in sixteenths.
    localparam logic [2:0] SHARE_UL   = 3'd1;
    localparam logic [2:0] SHARE_UP   = 3'd5;
    localparam logic [2:0] SHARE_UR   = 3'd3;
    localparam logic [2:0] SHARE_LEFT = 3'd7;

    localparam logic [PIX_W-1:0] MONO_BLACK = 8'd0;
    localparam logic [PIX_W-1:0] MONO_WHITE = 8'd255;

    // Which neighbors of the current pixel exist, and whether it closes the frame.
    typedef struct packed {
        logic has_up;
        logic has_left;
        logic has_right;
        logic frame_end;
    } pos_t;

    function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] r,
                                                 input logic [PIX_W-1:0] g,
                                                 input logic [PIX_W-1:0] b);
        logic [15:0] sum;
        sum = 16'(r) * 16'(COEF_R) + 16'(g) * 16'(COEF_G) + 16'(b) * 16'(COEF_B);
        return sum[15:8];
    endfunction

    // e*k/16 rounded half away from zero.
    function automatic logic signed [ERR_W-1:0] share_of(input logic signed [ERR_W-1:0] e,
                                                         input logic [2:0] k);
        logic [7:0]  mag;
        logic [10:0] prod;
        logic [7:0]  s;
        mag  = e[7] ? 8'(-e) : 8'(e);
        prod = 11'(mag) * 11'(k) + 11'd8;
        s    = 8'(prod >> 4);
        return e[7] ? (8'd0 - s) : s;
    endfunction

    function automatic logic [PIX_W-1:0] add_clamp(input logic [PIX_W-1:0] v,
                                                   input logic signed [ERR_W-1:0] s);
        logic signed [9:0] r;
        r = $signed({2'b00, v}) + 10'(s);
        if (r[9]) begin
            return 8'd0;
        end else if (r[8]) begin
            return 8'd255;
        end
        return r[7:0];
    endfunction

endpackage

// File: rtl/core/gedd_line_mem.sv
`timescale 1ns / 1ps

module gedd_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr0,
    input  logic [AW-1:0] raddr1,
    output logic [DW-1:0] rdata0,
    output logic [DW-1:0] rdata1
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rd0_reg;
    logic [DW-1:0] rd1_reg;

    // Reads return the contents from before a write at the same edge.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rd0_reg <= mem_reg[raddr0];
            rd1_reg <= mem_reg[raddr1];
        end
    end

    assign rdata0 = rd0_reg;
    assign rdata1 = rd1_reg;

endmodule

// File: rtl/core/gedd_raster.sv
`timescale 1ns / 1ps

module gedd_raster #(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [gedd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gedd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             advance,
    output logic [CW-1:0]                    col,
    output gedd_pkg::pos_t                   pos
);

    import gedd_pkg::*;

    localparam int CMPW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;

    logic [WIDTH_REG_W-1:0]  width_reg, width_next;
    logic [HEIGHT_REG_W-1:0] height_reg, height_next;
    logic [CW-1:0]           col_reg, col_next;
    logic [HEIGHT_REG_W-1:0] row_reg, row_next;

    logic [CMPW-1:0]         w_ext;
    logic [CMPW-1:0]         w_eff;
    logic [CMPW-1:0]         col_inc;
    logic [HEIGHT_REG_W:0]   row_inc;
    logic [HEIGHT_REG_W:0]   h_eff;
    logic                    has_right;
    logic                    last_row;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_next  = cfg_data[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT: height_next = cfg_data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_ext = CMPW'(width_reg);
        if (width_reg == '0) begin
            w_eff = CMPW'(1);
        end else if (w_ext > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        h_eff     = (height_reg == '0) ? (HEIGHT_REG_W + 1)'(1) : {1'b0, height_reg};
        col_inc   = CMPW'(col_reg) + CMPW'(1);
        row_inc   = {1'b0, row_reg} + (HEIGHT_REG_W + 1)'(1);
        has_right = col_inc < w_eff;
        last_row  = row_inc >= h_eff;

        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (has_right) begin
                col_next = col_inc[CW-1:0];
            end else begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[HEIGHT_REG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_REG_W'(1);
            height_reg <= HEIGHT_REG_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    assign col           = col_reg;
    assign pos.has_up    = row_reg != '0;
    assign pos.has_left  = col_reg != '0;
    assign pos.has_right = has_right;
    assign pos.frame_end = !has_right && last_row;

endmodule

// File: rtl/core/gedd_diffuse.sv
`timescale 1ns / 1ps

module gedd_diffuse (
    input  logic [gedd_pkg::PIX_W-1:0] gray,
    input  gedd_pkg::pos_t             pos,
    input  logic [gedd_pkg::ERR_W-1:0] err_ul,
    input  logic [gedd_pkg::ERR_W-1:0] err_up,
    input  logic [gedd_pkg::ERR_W-1:0] err_ur,
    input  logic [gedd_pkg::ERR_W-1:0] err_left,
    output logic [gedd_pkg::PIX_W-1:0] mono,
    output logic [gedd_pkg::ERR_W-1:0] err
);

    import gedd_pkg::*;

    logic [PIX_W-1:0] v_ul, v_up, v_ur, v_left;

    // Shares are added one at a time, each followed by a clamp to 0..255.
    always_comb begin
        v_ul   = (pos.has_up && pos.has_left)
               ? add_clamp(gray, share_of($signed(err_ul), SHARE_UL)) : gray;
        v_up   = pos.has_up ? add_clamp(v_ul, share_of($signed(err_up), SHARE_UP)) : v_ul;
        v_ur   = (pos.has_up && pos.has_right)
               ? add_clamp(v_up, share_of($signed(err_ur), SHARE_UR)) : v_up;
        v_left = pos.has_left
               ? add_clamp(v_ur, share_of($signed(err_left), SHARE_LEFT)) : v_ur;
        mono   = v_left[7] ? MONO_WHITE : MONO_BLACK;
        err    = v_left - mono;
    end

endmodule

// File: rtl/core/gray_error_diffusion_dither.sv
`timescale 1ns / 1ps

// Grayscale Floyd-Steinberg dither for a raster-order RGB pixel stream.
// Pixels arrive on the s_ channel (s_red, s_green, s_blue) under valid/ready;
// each request yields exactly one result request on the m_ channel carrying
// m_mono_value (0 or 255) and m_end_of_frame, set on the last pixel of a frame.
// Frame geometry is set through the cfg_ write channel: index 0 is the image
// width, index 1 the image height. cfg_ready is always high; write only while
// no pixel is in flight.
// An accepted pixel is registered in stage 1, then in the output register that
// drives m_valid. Throughput is one pixel per clock unless the receiver stalls.
// The rate rests on the error line memory: one read of the row above (two ports,
// current and next column) at accept and one write-back of the new error as
// stage 1 advances, forwarded when it hits an address read at the same edge.
// When the receiver stalls, the output register holds the result and the
// pipeline stage behind it holds one more pixel; s_ready drops only when both
// are full. Reset clears the counters, the left and upper-left errors and all
// valid flags, and sets width and height to 1. The line memory is not cleared;
// the first row of a frame never reads it.
module gray_error_diffusion_dither #(
    parameter int MAX_WIDTH = gedd_pkg::DEF_MAX_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [gedd_pkg::PIX_W-1:0]       s_red,
    input  logic [gedd_pkg::PIX_W-1:0]       s_green,
    input  logic [gedd_pkg::PIX_W-1:0]       s_blue,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [gedd_pkg::PIX_W-1:0]       m_mono_value,
    output logic                             m_end_of_frame,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gedd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gedd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import gedd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // Raster position of the next pixel to be accepted.
    logic [CW-1:0] col_cur;
    pos_t          pos_cur;
    logic          in_acc;
    logic          s1_adv;

    // Stage 1: pixel waiting for its line-memory read data.
    logic          s1_valid_reg;
    logic [PIX_W-1:0] gray_reg;
    pos_t          pos_reg;
    logic [CW-1:0] col_s1_reg;
    logic          fwd_up_reg;
    logic          fwd_ur_reg;
    logic [ERR_W-1:0] fwd_data_reg;

    // Errors of the left and upper-left neighbors.
    logic [ERR_W-1:0] left_err_reg;
    logic [ERR_W-1:0] ul_err_reg;

    // Output register.
    logic          out_valid_reg;
    logic [PIX_W-1:0] mono_reg;
    logic          eof_reg;

    logic [CW-1:0]    raddr0;
    logic [CW-1:0]    raddr1;
    logic [ERR_W-1:0] rdata0;
    logic [ERR_W-1:0] rdata1;
    logic [ERR_W-1:0] err_up;
    logic [ERR_W-1:0] err_ur;
    logic [PIX_W-1:0] mono_new;
    logic [ERR_W-1:0] err_new;

    assign cfg_ready = 1'b1;

    gedd_raster #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_raster (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (in_acc),
        .col       (col_cur),
        .pos       (pos_cur)
    );

    // Stage 1 moves on whenever the output register is empty or being drained.
    assign s1_adv  = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign in_acc  = s_valid && s_ready;

    // The upper-right address is only used when that column lies inside the row.
    assign raddr0 = col_cur;
    assign raddr1 = pos_cur.has_right ? (col_cur + CW'(1)) : col_cur;

    gedd_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (ERR_W)
    ) u_line_mem (
        .aclk   (aclk),
        .we     (s1_adv),
        .waddr  (col_s1_reg),
        .wdata  (err_new),
        .re     (in_acc),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    // A write-back landing on the same edge as a read is not seen by the read,
    // so the freshly computed error is forwarded in its place.
    assign err_up = fwd_up_reg ? fwd_data_reg : rdata0;
    assign err_ur = fwd_ur_reg ? fwd_data_reg : rdata1;

    gedd_diffuse u_diffuse (
        .gray     (gray_reg),
        .pos      (pos_reg),
        .err_ul   (ul_err_reg),
        .err_up   (err_up),
        .err_ur   (err_ur),
        .err_left (left_err_reg),
        .mono     (mono_new),
        .err      (err_new)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            gray_reg     <= gray_of(s_red, s_green, s_blue);
            pos_reg      <= pos_cur;
            col_s1_reg   <= col_cur;
            fwd_up_reg   <= s1_adv && (col_s1_reg == raddr0);
            fwd_ur_reg   <= s1_adv && (col_s1_reg == raddr1);
            fwd_data_reg <= err_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_err_reg <= '0;
            ul_err_reg   <= '0;
        end else if (s1_adv) begin
            left_err_reg <= err_new;
            ul_err_reg   <= pos_reg.has_up ? err_up : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            mono_reg <= mono_new;
            eof_reg  <= pos_reg.frame_end;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_mono_value   = mono_reg;
    assign m_end_of_frame = eof_reg;

`ifndef ASSERT_OFF
    // A result is always pure black or pure white.
    a_mono_binary: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (mono_reg == MONO_BLACK || mono_reg == MONO_WHITE))
        else $error("dither output is neither black nor white");

    // Where the upper-right column exists, the current and upper-right reads
    // never both hit the in-flight write.
    a_fwd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && pos_reg.has_right) |-> !(fwd_up_reg && fwd_ur_reg))
        else $error("both line-memory reads forwarded from one write");

    // With both stages full and the receiver stalled, no new pixel is taken.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("pixel accepted while the pipeline is full");

    // A frame end rewinds the raster to the first column of the first row.
    a_frame_rewind: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && pos_cur.frame_end) |=> (col_cur == '0 && !pos_cur.has_up))
        else $error("raster position not rewound after frame end");
`endif

endmodule

// File: bench/gray_error_diffusion_dither_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the grayscale Floyd-Steinberg dither block.
module gray_error_diffusion_dither_tb;
    import gedd_pkg::*;

    localparam int LINE_MAX       = DEF_MAX_WIDTH;
    localparam int CLK_PERIOD     = 12;
    localparam int RANDOM_PIXELS  = 1150;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_REPORTS    = 40;

    // Indexes that map to no register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic {ROW_PIXEL, ROW_REGISTER} stim_kind_t;

    typedef struct packed {
        logic [PIX_W-1:0] mono;
        logic             eof;
    } mono_result_t;

    // One row of the directed table: either a pixel request or a register write.
    // Rows with "typed" set carry an expected result that is obvious by hand.
    typedef struct packed {
        stim_kind_t            kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        logic [PIX_W-1:0]      red;
        logic [PIX_W-1:0]      green;
        logic [PIX_W-1:0]      blue;
        logic                  typed;
        mono_result_t          result;
    } stim_row_t;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic [PIX_W-1:0]      s_red          = '0;
    logic [PIX_W-1:0]      s_green        = '0;
    logic [PIX_W-1:0]      s_blue         = '0;
    logic                  m_ready        = 1'b0;
    logic                  cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic [PIX_W-1:0]      m_mono_value;
    logic                  m_end_of_frame;
    logic                  cfg_ready;

    // Shadow copy of the block's state, kept by the dither predictor.
    logic [ERR_W-1:0]        err_line [LINE_MAX];
    logic [ERR_W-1:0]        left_err;
    logic [ERR_W-1:0]        upleft_err;
    int                      pred_col;
    int                      pred_row;
    int                      line_extent;
    logic [WIDTH_REG_W-1:0]  cfg_width;
    logic [HEIGHT_REG_W-1:0] cfg_height;

    mono_result_t pending_results [$];
    stim_row_t    directed_rows [$];

    int  mismatch_count  = 0;
    int  result_count    = 0;
    int  cycle_count     = 0;
    bit  no_idle         = 1'b0;
    int  holdoff_asked   = 0;
    int  holdoff_served  = 0;

    gray_error_diffusion_dither i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mono_value   (m_mono_value),
        .m_end_of_frame (m_end_of_frame),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        forever begin
            #(CLK_PERIOD / 2) aclk = ~aclk;
        end
    end

    // The watchdog ends a hung run. The normal run is far shorter than this.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Report one mismatch on one line. Printing stops after a while so that a
    // badly broken block cannot flood the log, but every mismatch is counted.
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
    endtask

    // Error share e*k/16, rounded half away from zero.
    function automatic int error_share(input logic [ERR_W-1:0] err_bits, input int weight);
        int e;
        e = $signed(err_bits);
        if (e >= 0) begin
            return (e * weight + 8) >>> 4;
        end
        return -(((-e) * weight + 8) >>> 4);
    endfunction

    function automatic int add_saturate(input int v, input int s);
        int r;
        r = v + s;
        if (r > 255) begin
            r = 255;
        end
        if (r < 0) begin
            r = 0;
        end
        return r;
    endfunction

    // Register write as the block sees it, mirrored into the predictor.
    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        if (idx == CFG_IMAGE_WIDTH) begin
            cfg_width = value[WIDTH_REG_W-1:0];
        end else if (idx == CFG_IMAGE_HEIGHT) begin
            cfg_height = value[HEIGHT_REG_W-1:0];
        end
    endtask

    // Dither one pixel against the shadow state and advance the raster position.
    task automatic predict_dither(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                  input logic [PIX_W-1:0] b, output mono_result_t res);
        int               w;
        int               h;
        int               c;
        int               v;
        int               e;
        bit               up;
        bit               left;
        bit               right;
        bit               row_end;
        bit               frame_end;
        logic [ERR_W-1:0] above;

        // Out-of-range geometry falls back to the nearest legal value.
        w = cfg_width;
        if (w == 0) begin
            w = 1;
        end
        if (w > LINE_MAX) begin
            w = LINE_MAX;
        end
        h = cfg_height;
        if (h == 0) begin
            h = 1;
        end
        c = pred_col;
        above = '0;

        v = (int'(COEF_R) * int'(r) + int'(COEF_G) * int'(g) + int'(COEF_B) * int'(b)) >> 8;
        up    = pred_row > 0;
        left  = c > 0;
        right = (c + 1) < w;

        // Shares are added one at a time, each followed by its own clamp.
        if (up) begin
            above = err_line[c];
            if (left) begin
                v = add_saturate(v, error_share(upleft_err, int'(SHARE_UL)));
            end
            v = add_saturate(v, error_share(above, int'(SHARE_UP)));
            if (right) begin
                v = add_saturate(v, error_share(err_line[c + 1], int'(SHARE_UR)));
            end
        end
        if (left) begin
            v = add_saturate(v, error_share(left_err, int'(SHARE_LEFT)));
        end

        res.mono = (v < 128) ? MONO_BLACK : MONO_WHITE;
        e = v - int'(res.mono);

        upleft_err  = above;
        err_line[c] = e[ERR_W-1:0];
        left_err    = e[ERR_W-1:0];
        if (c + 1 > line_extent) begin
            line_extent = c + 1;
        end

        // A row also ends early when the width shrank below the current column.
        row_end   = !right;
        frame_end = row_end && (pred_row + 1 >= h);
        res.eof   = frame_end;
        if (row_end) begin
            pred_col = 0;
            pred_row = frame_end ? 0 : ((pred_row + 1) & 16'hFFFF);
        end else begin
            pred_col = c + 1;
        end
    endtask

    // Offer one pixel request and hold it until accepted. Valid is never lowered
    // here after acceptance, so back-to-back requests keep it high unless an idle is drawn.
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b, input logic typed,
                              input mono_result_t typed_res);
        mono_result_t res;
        if (!no_idle) begin
            while ($urandom_range(99) < 15) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_red   <= r;
        s_green <= g;
        s_blue  <= b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_dither(r, g, b, res);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // Stop offering pixels and wait until every result has been taken. Every
    // pixel yields a result, so an empty queue means the block is idle.
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_register(idx, value);
        @(posedge aclk);
    endtask

    // Channel levels that favor the extremes and the band around the threshold.
    function automatic logic [PIX_W-1:0] pick_level();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(135, 120));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // A width that is mostly small. Below the first row of a frame the width may
    // only grow as far as line entries have been written, so that the row above
    // is never read where it holds nothing.
    function automatic logic [WIDTH_REG_W-1:0] pick_width();
        int cand;
        int eff;
        case ($urandom_range(9))
            0: cand = 0;
            1: cand = 1;
            2: cand = 2;
            3: cand = $urandom_range(64, 17);
            default: cand = $urandom_range(16, 3);
        endcase
        eff = (cand == 0) ? 1 : cand;
        if (pred_row != 0 && eff > line_extent) begin
            cand = $urandom_range(line_extent, 1);
        end
        return WIDTH_REG_W'(cand);
    endfunction

    function automatic logic [HEIGHT_REG_W-1:0] pick_height();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(6, 2));
        endcase
    endfunction

    function automatic stim_row_t pixel_row(input logic [PIX_W-1:0] r,
                                            input logic [PIX_W-1:0] g,
                                            input logic [PIX_W-1:0] b);
        stim_row_t row;
        row       = '0;
        row.kind  = ROW_PIXEL;
        row.red   = r;
        row.green = g;
        row.blue  = b;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [PIX_W-1:0] r,
                                            input logic [PIX_W-1:0] g,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] mono, input logic eof);
        stim_row_t row;
        row             = pixel_row(r, g, b);
        row.typed       = 1'b1;
        row.result.mono = mono;
        row.result.eof  = eof;
        return row;
    endfunction

    function automatic stim_row_t register_row(input logic [CFG_IDX_W-1:0] idx,
                                               input logic [CFG_DATA_W-1:0] value);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_REGISTER;
        row.reg_index = idx;
        row.reg_value = value;
        return row;
    endfunction

    // The receiver drops ready at random, with a chance of 15 in a hundred. On
    // request it also holds ready low for a long stretch, so that the block fills
    // up and stalls its input while the sender keeps offering pixels.
    initial begin
        forever begin
            @(posedge aclk);
            if (holdoff_asked != holdoff_served) begin
                m_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                holdoff_served++;
            end
            m_ready <= no_idle || ($urandom_range(99) >= 15);
        end
    end

    // Each result request is checked against the oldest expected result.
    always @(posedge aclk) begin
        mono_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no pixel pending",
                                          result_count));
            end else begin
                want = pending_results.pop_front();
                if (m_mono_value !== want.mono) begin
                    report_mismatch($sformatf("result %0d mono_value got %0d expected %0d",
                                              result_count, m_mono_value, want.mono));
                end
                if (m_end_of_frame !== want.eof) begin
                    report_mismatch($sformatf("result %0d end_of_frame got %0b expected %0b",
                                              result_count, m_end_of_frame, want.eof));
                end
            end
            result_count++;
        end
    end

    initial begin
        int  phase;
        int  random_sent;
        int  count;
        int  sel;
        bit  wide;

        // Predictor starts from the reset state. The line store is left alone,
        // since the first row of a frame never reads it.
        left_err    = '0;
        upleft_err  = '0;
        pred_col    = 0;
        pred_row    = 0;
        line_extent = 0;
        cfg_width   = WIDTH_REG_W'(1);
        cfg_height  = HEIGHT_REG_W'(1);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table. At the reset geometry of 1x1 every pixel is its own
        // frame and has no neighbors, so the result is just the gray threshold.
        directed_rows.push_back(typed_row(8'd0,   8'd0,   8'd0,   MONO_BLACK, 1'b1));
        directed_rows.push_back(typed_row(8'd255, 8'd255, 8'd255, MONO_WHITE, 1'b1));
        directed_rows.push_back(typed_row(8'd255, 8'd0,   8'd0,   MONO_BLACK, 1'b1));
        directed_rows.push_back(typed_row(8'd0,   8'd255, 8'd0,   MONO_WHITE, 1'b1));
        directed_rows.push_back(typed_row(8'd0,   8'd0,   8'd255, MONO_BLACK, 1'b1));
        directed_rows.push_back(typed_row(8'd127, 8'd127, 8'd127, MONO_BLACK, 1'b1));
        directed_rows.push_back(typed_row(8'd128, 8'd128, 8'd128, MONO_WHITE, 1'b1));
        // Zero width and zero height behave as one; unmapped indexes do nothing.
        directed_rows.push_back(register_row(CFG_IMAGE_WIDTH, 16'd0));
        directed_rows.push_back(register_row(CFG_IMAGE_HEIGHT, 16'd0));
        directed_rows.push_back(register_row(CFG_SPARE_2, 16'hFFFF));
        directed_rows.push_back(register_row(CFG_SPARE_3, 16'hFFFF));
        directed_rows.push_back(typed_row(8'd128, 8'd128, 8'd128, MONO_WHITE, 1'b1));
        directed_rows.push_back(typed_row(8'd127, 8'd127, 8'd127, MONO_BLACK, 1'b1));
        // A full 4x3 frame of threshold and saturated levels drives the error
        // shares to both clamps and touches every neighbor combination.
        directed_rows.push_back(register_row(CFG_IMAGE_WIDTH, 16'd4));
        directed_rows.push_back(register_row(CFG_IMAGE_HEIGHT, 16'd3));
        directed_rows.push_back(pixel_row(8'd127, 8'd127, 8'd127));
        directed_rows.push_back(pixel_row(8'd127, 8'd127, 8'd127));
        directed_rows.push_back(pixel_row(8'd255, 8'd255, 8'd255));
        directed_rows.push_back(pixel_row(8'd0,   8'd0,   8'd0));
        directed_rows.push_back(pixel_row(8'd0,   8'd0,   8'd0));
        directed_rows.push_back(pixel_row(8'd255, 8'd255, 8'd255));
        directed_rows.push_back(pixel_row(8'd128, 8'd128, 8'd128));
        directed_rows.push_back(pixel_row(8'd127, 8'd127, 8'd127));
        directed_rows.push_back(pixel_row(8'd255, 8'd255, 8'd255));
        directed_rows.push_back(pixel_row(8'd0,   8'd0,   8'd0));
        directed_rows.push_back(pixel_row(8'd127, 8'd127, 8'd127));
        directed_rows.push_back(pixel_row(8'd128, 8'd128, 8'd128));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REGISTER) begin
                settle_pipeline();
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end else begin
                send_pixel(directed_rows[i].red, directed_rows[i].green,
                           directed_rows[i].blue, directed_rows[i].typed,
                           directed_rows[i].result);
            end
        end

        // Random phases. Each phase drains the block, which also serves as the
        // sender's pause until every expected result has come, then rewrites the
        // geometry, often mid-frame, and streams random pixels.
        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            settle_pipeline();
            wide = (phase == 2) || (phase == 4);

            // The widest settings are entered at a frame start, so that the
            // line store is filled before any row reads it. A width of one and a
            // height of one close the current frame on the next pixel.
            if (wide && (pred_row != 0 || pred_col != 0)) begin
                write_register(CFG_IMAGE_WIDTH, 16'd1);
                write_register(CFG_IMAGE_HEIGHT, 16'd1);
                while (pred_row != 0 || pred_col != 0) begin
                    send_pixel(pick_level(), pick_level(), pick_level(), 1'b0, '0);
                    random_sent++;
                end
                settle_pipeline();
            end

            if (phase == 2) begin
                // Every width bit set: the block must cap the row at its maximum.
                write_register(CFG_IMAGE_WIDTH, 16'h07FF);
                write_register(CFG_IMAGE_HEIGHT, 16'hFFFF);
            end else if (phase == 4) begin
                write_register(CFG_IMAGE_WIDTH, CFG_DATA_W'(LINE_MAX));
                write_register(CFG_IMAGE_HEIGHT, 16'd2);
            end else begin
                sel = $urandom_range(2);
                if (sel != 1) begin
                    // Bits above the width field are junk that the block ignores.
                    write_register(CFG_IMAGE_WIDTH,
                                   {5'($urandom), pick_width()});
                end
                if (sel != 0) begin
                    write_register(CFG_IMAGE_HEIGHT, pick_height());
                end
            end

            no_idle = (phase == 6);
            if (phase == 3) begin
                holdoff_asked <= holdoff_asked + 1;
            end

            if (wide) begin
                count = $urandom_range(60, 30);
            end else if (phase == 6) begin
                count = 150;
            end else if (phase == 3) begin
                count = $urandom_range(100, 40);
            end else begin
                count = $urandom_range(100, 15);
            end

            repeat (count) begin
                send_pixel(pick_level(), pick_level(), pick_level(), 1'b0, '0);
                random_sent++;
            end
            phase++;
        end

        settle_pipeline();
        no_idle = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
